// ----- design/ps2md_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int REPORT_WIDTH       = 32;

  // packet_mode register codes
  localparam logic [1:0] MODE_STANDARD = 2'd0;
  localparam logic [1:0] MODE_WHEEL    = 2'd1;
  localparam logic [1:0] MODE_FIVE_BTN = 2'd2;
  localparam logic [1:0] MODE_ALT_STD  = 2'd3;

  // header byte bits
  localparam int HDR_SYNC  = 3;
  localparam int HDR_XSIGN = 4;
  localparam int HDR_YSIGN = 5;
  localparam int HDR_XOVF  = 6;
  localparam int HDR_YOVF  = 7;

  // clamp values for an overflowed 9-bit delta
  localparam logic signed [8:0] DELTA_POS_MAX = 9'sd255;
  localparam logic signed [8:0] DELTA_NEG_MAX = -9'sd255;

  // one assembled packet, handed from the assembler to the decoder
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic [7:0] extra;
    logic [1:0] mode;
  } packet_t;

endpackage

// ----- design/ps2md_byte_if.sv -----
// ----------------------------------------------------------------------------
// ps2md_byte_if
// Valid/ready channel carrying one received mouse byte.
// ----------------------------------------------------------------------------
interface ps2md_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- design/ps2md_result_if.sv -----
// ----------------------------------------------------------------------------
// ps2md_result_if
// Valid/ready channel carrying one decoded mouse packet.
// ----------------------------------------------------------------------------
interface ps2md_result_if;
  logic               valid;
  logic               ready;
  logic signed [8:0]  delta_x;
  logic signed [9:0]  delta_y_screen;
  logic signed [7:0]  wheel_delta;
  logic [4:0]         button_state;
  logic [4:0]         button_changes;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic               anything_changed;

  modport source (output valid, output delta_x, output delta_y_screen, output wheel_delta,
                  output button_state, output button_changes, output position_x,
                  output position_y, output anything_changed, input ready);
  modport sink   (input valid, input delta_x, input delta_y_screen, input wheel_delta,
                  input button_state, input button_changes, input position_x,
                  input position_y, input anything_changed, output ready);
endinterface

// ----- design/ps2md_assembler.sv -----
// ----------------------------------------------------------------------------
// ps2md_assembler
// Collects header, movement and optional fourth byte into a packet register.
// ----------------------------------------------------------------------------
module ps2md_assembler
  import ps2md_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] mode,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  output logic       byte_ready,
  output logic       pkt_valid,
  output packet_t    pkt,
  input  logic       pkt_ready
);

  // byte phase codes
  localparam logic [1:0] PH_WAIT_HDR = 2'd0;
  localparam logic [1:0] PH_GOT_HDR  = 2'd1;
  localparam logic [1:0] PH_GOT_X    = 2'd2;
  localparam logic [1:0] PH_GOT_Y    = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic       pkt_valid_r, pkt_valid_nxt;
  packet_t    pkt_r, pkt_nxt;
  logic       take;
  logic       four_byte;

  assign byte_ready = !pkt_valid_r || pkt_ready;
  assign take       = byte_valid && byte_ready;
  assign four_byte  = (mode == MODE_WHEEL) || (mode == MODE_FIVE_BTN);

  always_comb begin
    phase_nxt     = phase_r;
    header_nxt    = header_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pkt_nxt       = pkt_r;
    pkt_valid_nxt = pkt_valid_r && !pkt_ready;
    if (take) begin
      unique case (phase_r)
        PH_WAIT_HDR: begin
          if (byte_data[HDR_SYNC]) begin
            header_nxt = byte_data;
            phase_nxt  = PH_GOT_HDR;
          end
        end
        PH_GOT_HDR: begin
          x_nxt     = byte_data;
          phase_nxt = PH_GOT_X;
        end
        PH_GOT_X: begin
          y_nxt = byte_data;
          if (four_byte) begin
            phase_nxt = PH_GOT_Y;
          end else begin
            phase_nxt     = PH_WAIT_HDR;
            pkt_valid_nxt = 1'b1;
            pkt_nxt       = '{header: header_r, x_byte: x_r, y_byte: byte_data,
                              extra: 8'd0, mode: mode};
          end
        end
        default: begin
          phase_nxt     = PH_WAIT_HDR;
          pkt_valid_nxt = 1'b1;
          pkt_nxt       = '{header: header_r, x_byte: x_r, y_byte: y_r,
                            extra: byte_data, mode: mode};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_HDR;
      header_r    <= 8'd0;
      x_r         <= 8'd0;
      y_r         <= 8'd0;
      pkt_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      header_r    <= header_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      pkt_valid_r <= pkt_valid_nxt;
    end
    pkt_r <= pkt_nxt;
  end

  assign pkt_valid = pkt_valid_r;
  assign pkt       = pkt_r;

endmodule

// ----- design/ps2md_decoder.sv -----
// ----------------------------------------------------------------------------
// ps2md_decoder
// Turns a packet into deltas and buttons, updates positions, holds the result.
// ----------------------------------------------------------------------------
module ps2md_decoder
  import ps2md_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     pkt_valid,
  input  packet_t  pkt,
  output logic     pkt_ready,
  ps2md_result_if.source res
);

  logic signed [8:0]  dx, dy;
  logic signed [9:0]  dys;
  logic signed [7:0]  wheel;
  logic [4:0]         buttons, changed, rep_mask;
  logic               any;
  logic               load;

  logic signed [POSITION_WIDTH-1:0] acc_x_r, acc_x_nxt;
  logic signed [POSITION_WIDTH-1:0] acc_y_r, acc_y_nxt;
  logic [4:0]         prev_btn_r;
  logic               valid_r;
  logic signed [8:0]  dx_r;
  logic signed [9:0]  dys_r;
  logic signed [7:0]  wheel_r;
  logic [4:0]         buttons_r, changed_r;
  logic               any_r;

  assign pkt_ready = !valid_r || res.ready;
  assign load      = pkt_valid && pkt_ready;

  always_comb begin
    dx = $signed({pkt.header[HDR_XSIGN], pkt.x_byte});
    if (pkt.header[HDR_XOVF]) dx = pkt.header[HDR_XSIGN] ? DELTA_NEG_MAX : DELTA_POS_MAX;
    dy = $signed({pkt.header[HDR_YSIGN], pkt.y_byte});
    if (pkt.header[HDR_YOVF]) dy = pkt.header[HDR_YSIGN] ? DELTA_NEG_MAX : DELTA_POS_MAX;
    dys     = -10'(dy);
    buttons = {2'b00, pkt.header[2:0]};
    rep_mask = 5'h07;
    unique case (pkt.mode)
      MODE_WHEEL: wheel = $signed(pkt.extra);
      MODE_FIVE_BTN: begin
        wheel    = 8'($signed(pkt.extra[3:0]));
        buttons  = {pkt.extra[5], pkt.extra[4], pkt.header[2:0]};
        rep_mask = 5'h1F;
      end
      default: wheel = 8'sd0;
    endcase
    changed   = buttons ^ prev_btn_r;
    any       = (dx != 0) || (dys != 0) || (wheel != 0) || ((changed & rep_mask) != 0);
    acc_x_nxt = acc_x_r + POSITION_WIDTH'(dx);
    acc_y_nxt = acc_y_r + POSITION_WIDTH'(dys);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      prev_btn_r <= 5'd0;
      acc_x_r    <= '0;
      acc_y_r    <= '0;
    end else if (load) begin
      valid_r    <= 1'b1;
      prev_btn_r <= buttons;
      acc_x_r    <= acc_x_nxt;
      acc_y_r    <= acc_y_nxt;
    end else if (res.ready) begin
      valid_r    <= 1'b0;
    end
    if (load) begin
      dx_r      <= dx;
      dys_r     <= dys;
      wheel_r   <= wheel;
      buttons_r <= buttons;
      changed_r <= changed;
      any_r     <= any;
    end
  end

  assign res.valid            = valid_r;
  assign res.delta_x          = dx_r;
  assign res.delta_y_screen   = dys_r;
  assign res.wheel_delta      = wheel_r;
  assign res.button_state     = buttons_r;
  assign res.button_changes   = changed_r;
  assign res.position_x       = REPORT_WIDTH'(acc_x_r);
  assign res.position_y       = REPORT_WIDTH'(acc_y_r);
  assign res.anything_changed = any_r;

endmodule

// ----- design/ps2_mouse_packet_decoder_core.sv -----
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_core
// PS/2 mouse packet decoder: standard 3-byte, wheel and five-button 4-byte.
// ----------------------------------------------------------------------------
// Feed received mouse bytes on in_byte; one decoded packet leaves on
// out_result per finished packet. A byte is taken every cycle while
// in_byte.ready is high; a completed packet is held in the packet register
// until the decoder loads it, decoded, into the result register.
// The packet register between assembler and decoder acts as a skid
// slot, so bytes keep flowing while a result waits; in_byte.ready drops only
// when both the packet slot and the result register are full. Headers
// without bit 3 set are dropped. packet_mode (cfg_wdata on cfg_we) selects
// 3-byte (0 or 3), wheel (1) or five-button (2) packets and is to be changed
// only while the block is idle. Positions are POSITION_WIDTH-bit running sums
// reported as 32-bit signed values.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_core
  import ps2md_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  ps2md_byte_if.sink     in_byte,
  ps2md_result_if.source out_result
);

  logic [1:0] mode_r;
  logic       pkt_valid;
  logic       pkt_ready;
  packet_t    pkt;

  // packet_mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STANDARD;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // byte phase tracking and packet capture
  ps2md_assembler u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .byte_valid (in_byte.valid),
    .byte_data  (in_byte.rx_byte),
    .byte_ready (in_byte.ready),
    .pkt_valid  (pkt_valid),
    .pkt        (pkt),
    .pkt_ready  (pkt_ready)
  );

  // delta decode, position update and result register
  ps2md_decoder #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_valid (pkt_valid),
    .pkt       (pkt),
    .pkt_ready (pkt_ready),
    .res       (out_result)
  );

  // a stalled packet slot keeps its packet until the decoder takes it
  a_pkt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt))
    else $error("packet slot lost or changed while stalled");

  // input back-pressure only when both slots are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_byte.ready |-> pkt_valid && out_result.valid && !out_result.ready)
    else $error("input stalled with a free slot");

  // a result flagged unchanged carries no movement
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_result.valid && !out_result.anything_changed |->
      out_result.delta_x == 0 && out_result.delta_y_screen == 0 &&
      out_result.wheel_delta == 0)
    else $error("movement reported without change flag");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ps2_mouse_packet_decoder_core. Mouse bytes are
// driven with random gaps and the result channel is stalled at random. Each
// accepted byte goes to an in-bench packet decoder that predicts the report.
// Every report transfer is checked field by field against the oldest
// prediction. packet_mode is moved between all four codes while the block is
// idle, which includes switches in the middle of a packet.
// ----------------------------------------------------------------------------
module testbench;
  import ps2md_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int BYTE_TARGET   = 1350;

  // packet assembly phases of the predictor
  localparam logic [1:0] WAIT_HDR = 2'd0;
  localparam logic [1:0] GOT_HDR  = 2'd1;
  localparam logic [1:0] GOT_X    = 2'd2;
  localparam logic [1:0] GOT_Y    = 2'd3;

  typedef struct {
    logic signed [8:0]  delta_x;
    logic signed [9:0]  delta_y_screen;
    logic signed [7:0]  wheel_delta;
    logic [4:0]         button_state;
    logic [4:0]         button_changes;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic               anything_changed;
  } mouse_report_t;

  // Packet decoder in bench form plus the queue of reports still owed.
  class mouse_scoreboard;
    logic [1:0]         mode         = MODE_STANDARD;
    logic [1:0]         phase        = WAIT_HDR;
    logic [7:0]         hdr          = 8'h00;
    logic [7:0]         x_raw        = 8'h00;
    logic [7:0]         y_raw        = 8'h00;
    logic [4:0]         last_buttons = 5'h00;
    logic signed [31:0] pos_x        = 32'sd0;
    logic signed [31:0] pos_y        = 32'sd0;
    mouse_report_t      pending_reports[$];
    int                 errors       = 0;
    int                 reports_seen = 0;

    function bit four_byte();
      return mode == MODE_WHEEL || mode == MODE_FIVE_BTN;
    endfunction

    function logic signed [9:0] clamp_delta(logic [7:0] low, logic sgn, logic ovf);
      if (ovf) return sgn ? DELTA_NEG_MAX : DELTA_POS_MAX;
      return $signed({sgn, low});
    endfunction

    function void decode_packet(logic [7:0] extra);
      mouse_report_t     r;
      logic signed [9:0] dx;
      logic signed [9:0] dy;
      logic [4:0]        mask;
      dx = clamp_delta(x_raw, hdr[HDR_XSIGN], hdr[HDR_XOVF]);
      dy = clamp_delta(y_raw, hdr[HDR_YSIGN], hdr[HDR_YOVF]);
      r.delta_x        = dx[8:0];
      r.delta_y_screen = -dy;
      r.wheel_delta    = 8'sd0;
      r.button_state   = {2'b00, hdr[2:0]};
      case (mode)
        MODE_WHEEL: r.wheel_delta = extra;
        MODE_FIVE_BTN: begin
          r.wheel_delta       = {{4{extra[3]}}, extra[3:0]};
          r.button_state[4:3] = extra[5:4];
        end
        default: ;
      endcase
      r.button_changes = r.button_state ^ last_buttons;
      // side and extra buttons only count as a change in five-button mode
      mask = (mode == MODE_FIVE_BTN) ? 5'h1F : 5'h07;
      r.anything_changed = (dx != 0) || (r.delta_y_screen != 0) ||
                           (r.wheel_delta != 0) || ((r.button_changes & mask) != 0);
      last_buttons = r.button_state;
      pos_x = pos_x + dx;
      pos_y = pos_y + r.delta_y_screen;
      r.position_x = pos_x;
      r.position_y = pos_y;
      pending_reports.push_back(r);
    endfunction

    // Returns 0 when the byte is a header without the sync bit.
    function bit note_byte(logic [7:0] b);
      logic [7:0] extra;
      extra = 8'h00;
      case (phase)
        WAIT_HDR: begin
          if (!b[HDR_SYNC]) return 1'b0;
          hdr   = b;
          phase = GOT_HDR;
          return 1'b1;
        end
        GOT_HDR: begin
          x_raw = b;
          phase = GOT_X;
          return 1'b1;
        end
        GOT_X: begin
          y_raw = b;
          if (four_byte()) begin
            phase = GOT_Y;
            return 1'b1;
          end
          phase = WAIT_HDR;
        end
        default: begin
          extra = b;
          phase = WAIT_HDR;
        end
      endcase
      decode_packet(extra);
      return 1'b1;
    endfunction

    function void field_check(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(mouse_report_t got);
      mouse_report_t want;
      if (pending_reports.size() == 0) begin
        $error("report transfer with no packet outstanding");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      reports_seen++;
      field_check("delta_x", want.delta_x, got.delta_x);
      field_check("delta_y_screen", want.delta_y_screen, got.delta_y_screen);
      field_check("wheel_delta", want.wheel_delta, got.wheel_delta);
      field_check("button_state", want.button_state, got.button_state);
      field_check("button_changes", want.button_changes, got.button_changes);
      field_check("position_x", want.position_x, got.position_x);
      field_check("position_y", want.position_y, got.position_y);
      field_check("anything_changed", want.anything_changed, got.anything_changed);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  ps2md_byte_if   in_if ();
  ps2md_result_if out_if ();

  ps2_mouse_packet_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (in_if),
    .out_result (out_if)
  );

  mouse_scoreboard sb = new();

  int            cycles          = 0;
  int            bytes_used      = 0;
  int            headers_dropped = 0;
  int            mode_writes     = 0;
  int            sink_hold       = 0;
  int            sink_roll;
  bit            sender_steady   = 1'b0;
  bit            sink_steady     = 1'b0;
  mouse_report_t seen;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sink: mostly ready, short stalls, the odd long one.
  always @(negedge clk) begin
    if (sink_steady) begin
      out_if.ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 65) begin
        out_if.ready <= 1'b1;
        sink_hold = $urandom_range(0, 4);
      end else if (sink_roll < 92) begin
        out_if.ready <= 1'b0;
        sink_hold = $urandom_range(0, 3);
      end else begin
        out_if.ready <= 1'b0;
        sink_hold = $urandom_range(8, 30);
      end
    end
  end

  // Every report transfer is checked as it happens.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.delta_x          = out_if.delta_x;
      seen.delta_y_screen   = out_if.delta_y_screen;
      seen.wheel_delta      = out_if.wheel_delta;
      seen.button_state     = out_if.button_state;
      seen.button_changes   = out_if.button_changes;
      seen.position_x       = out_if.position_x;
      seen.position_y       = out_if.position_y;
      seen.anything_changed = out_if.anything_changed;
      sb.check_result(seen);
    end
  end

  function automatic int sender_gap();
    int roll;
    if (sender_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One byte transfer. valid is left high when the next byte follows at once.
  task automatic send_byte(logic [7:0] b);
    int gap;
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (sb.note_byte(b)) bytes_used++;
    else headers_dropped++;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every owed report has come out.
  task automatic drain_reports();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_mode(logic [1:0] m);
    drain_reports();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.mode = m;
    mode_writes++;
  endtask

  // Well-formed packet with random content; a quiet one moves nothing.
  task automatic send_packet();
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
    logic [7:0] ex;
    bit         quiet;
    quiet = ($urandom_range(0, 5) == 0);
    hdr = quiet ? 8'h08 : (8'($urandom_range(0, 255)) | 8'h08);
    xb  = (quiet || $urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    yb  = (quiet || $urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    ex  = (quiet || $urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
    if (sb.four_byte()) send_byte(ex);
  endtask

  task automatic random_phase(int quota);
    int start;
    int roll;
    start = bytes_used;
    while (bytes_used - start < quota) begin
      // realign after a broken packet
      while (sb.phase != WAIT_HDR) send_byte(8'($urandom_range(0, 255)));
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // line noise: headers without the sync bit
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)) & 8'hF7);
      end else if (roll < 13) begin
        // packet cut short, then filled up with random bytes to realign
        send_byte(8'($urandom_range(0, 255)) | 8'h08);
        repeat ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_packet();
      end
    end
    // leave a packet half-built so the next mode write lands mid-packet
    if ($urandom_range(0, 2) == 0) begin
      send_byte(8'($urandom_range(0, 255)) | 8'h08);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = MODE_STANDARD;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and each mode in turn.
    apply_mode(MODE_STANDARD);
    send_byte(8'hF7);                     // no sync bit, dropped
    send_byte(8'h3F);                     // both signs, zero low bytes: -256
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hC8);                     // both overflow, positive clamp
    send_byte(8'h7F);
    send_byte(8'h01);
    apply_mode(MODE_WHEEL);
    send_byte(8'h08);                     // largest positive deltas, wheel -128
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h80);
    apply_mode(MODE_FIVE_BTN);
    send_byte(8'hFB);                     // negative clamp, side and extra held
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h3F);
    apply_mode(MODE_ALT_STD);             // code 3 behaves as 3-byte mode
    send_byte(8'h08);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h08);                     // repeat: nothing changed
    send_byte(8'h00);
    send_byte(8'h00);

    // Random phases, each under its own mode and idling pattern.
    while (bytes_used < BYTE_TARGET) begin
      apply_mode(2'($urandom_range(0, 3)));
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      random_phase(($urandom_range(0, 9) < 7) ? $urandom_range(15, 60) : $urandom_range(1, 8));
    end

    sink_steady = 1'b0;
    drain_reports();

    $display("Run covered %0d packet bytes, %0d unsynced headers dropped, %0d mode writes.",
             bytes_used, headers_dropped, mode_writes);
    $display("%0d reports checked, %0d mismatches.", sb.reports_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ps2md_pkg.sv
design/ps2md_byte_if.sv
design/ps2md_result_if.sv
design/ps2md_assembler.sv
design/ps2md_decoder.sv
design/ps2_mouse_packet_decoder_core.sv
tb/sv/testbench.sv
